>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OPP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define OPP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define OPP_ASSERT(lbl, clk, rst_n, prop)
`define OPP_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> design/opp_pkg.sv
// ----------------------------------------------------------------------------
// opp_pkg
// Types, constants and step functions of the orbit path point generator.
// ----------------------------------------------------------------------------
package opp_pkg;

  typedef enum logic [2:0] {
    REG_PATH_MODE,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_ORBIT_RADIUS,
    REG_WAVE_HEIGHT,
    REG_START_ANGLE,
    REG_END_ANGLE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FLAT,
    MODE_CYL,
    MODE_SPHERE,
    MODE_HELIX
  } path_mode_e;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;  // Q2.30
  localparam int unsigned ATAN_ENTRIES = 30;
  localparam int unsigned SQRT_STAGES  = 32;
  localparam int unsigned QUOT_BITS    = 33;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
  } cordic_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] quo;
  } div_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(int unsigned i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // Fold a turn angle into the half turn around zero; a separate flag marks the fold.
  function automatic cordic_t cordic_init(logic [31:0] a);
    cordic_t o;
    o.x = CORDIC_GAIN;
    o.y = '0;
    o.z = $signed({a[30], a[30], a[30:0]});
    return o;
  endfunction

  function automatic cordic_t cordic_rot(cordic_t s, int unsigned i);
    cordic_t o;
    logic signed [32:0] at;
    at = $signed({3'b000, atan_turn(i)});
    if (!s.z[32]) begin
      o.x = $signed(s.x) - ($signed(s.y) >>> i);
      o.y = $signed(s.y) + ($signed(s.x) >>> i);
      o.z = $signed(s.z) - at;
    end else begin
      o.x = $signed(s.x) + ($signed(s.y) >>> i);
      o.y = $signed(s.y) - ($signed(s.x) >>> i);
      o.z = $signed(s.z) + at;
    end
    return o;
  endfunction

  // One digit of the floor square root, digit k counted from the top.
  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned k);
    sqrt_t o;
    logic [63:0] b;
    logic [63:0] sum;
    b   = 64'd1 << (62 - 2 * k);
    sum = s.r + b;
    if (s.n >= sum) begin
      o.n = s.n - sum;
      o.r = (s.r >> 1) + b;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of a restoring division.
  function automatic div_t div_step(div_t s, logic [45:0] den, int unsigned b);
    div_t o;
    logic [78:0] trial;
    trial = {33'd0, den} << b;
    if ({15'd0, s.rem} >= trial) begin
      o.rem = s.rem - trial[63:0];
      o.quo = {s.quo[31:0], 1'b1};
    end else begin
      o.rem = s.rem;
      o.quo = {s.quo[31:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] sat32(logic signed [35:0] v);
    logic [31:0] o;
    if (v > 36'sd2147483647) begin
      o = 32'h7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      o = 32'h8000_0000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

endpackage

>>> design/orbit_path_point_generator.sv
// ----------------------------------------------------------------------------
// orbit_path_point_generator
// Streams 3-D orbit points for path positions: CORDIC sine/cosine, then
// circle, wave, helix or sphere-normalized offsets around a center.
// ----------------------------------------------------------------------------
//
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------
// config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// input    | in_valid_i / in_ready_o    | path_position_i
// output   | out_valid_o / out_ready_i  | point_x_o, point_y_o, point_z_o
//
// The pipeline takes one item per cycle while the output is not stalled.
// It is made up of the CORDIC rotations, a 32-digit square root
// and three 33-bit restoring dividers, one digit per stage.
// The pipeline moves as a whole when the output register is free or taken;
// the entry stage still takes an item while it is empty.
// Reset clears valid bits and loads the register defaults.
//
`include "assert_macros.svh"

module orbit_path_point_generator #(
  parameter int unsigned PHASE_BITS  = 16,
  parameter int unsigned SINE_STAGES = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [16:0]        path_position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o
);
  import opp_pkg::*;

  localparam int unsigned NST  = (SINE_STAGES < ATAN_ENTRIES) ? SINE_STAGES : ATAN_ENTRIES;
  localparam int unsigned PAD  = 32 - PHASE_BITS;
  localparam int unsigned CLST = NST - 1;
  localparam int unsigned SLST = SQRT_STAGES - 1;
  localparam int unsigned DLST = QUOT_BITS - 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  path_mode_e         mode_q;
  logic signed [31:0] center_x_q, center_y_q, center_z_q, height_q;
  logic [30:0]        radius_q;
  logic signed [23:0] start_q, end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_FLAT;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= 31'd65536;
      height_q   <= '0;
      start_q    <= '0;
      end_q      <= 24'sd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PATH_MODE:    mode_q     <= path_mode_e'(cfg_data_i[1:0]);
        REG_CENTER_X:     center_x_q <= cfg_data_i;
        REG_CENTER_Y:     center_y_q <= cfg_data_i;
        REG_CENTER_Z:     center_z_q <= cfg_data_i;
        REG_ORBIT_RADIUS: radius_q   <= cfg_data_i[30:0];
        REG_WAVE_HEIGHT:  height_q   <= cfg_data_i;
        REG_START_ANGLE:  start_q    <= cfg_data_i[23:0];
        REG_END_ANGLE:    end_q      <= cfg_data_i[23:0];
      endcase
    end
  end

  logic signed [31:0] rad_s;
  assign rad_s = $signed({1'b0, radius_q});

  // --------------------------------------------------------------------------
  // Flow control: whole pipe advances together, entry stage fills bubbles
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv, en0;
  logic v0_q;
  logic [16:0] t0_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign en0        = adv || !v0_q;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      t0_q <= path_position_i;
    end
  end

  // --------------------------------------------------------------------------
  // Phase: orbit angle start + t*(end-start), wave angle t, both in 2^-32 turn
  // --------------------------------------------------------------------------
  logic signed [24:0] ang_span;
  logic signed [42:0] ang_prod;
  logic [31:0]        orb_turn, wav_turn;
  logic               ph_v_q;
  logic [PHASE_BITS-1:0] ph_orb_q, ph_wav_q;
  logic [16:0]        ph_t_q;

  assign ang_span = $signed({end_q[23], end_q}) - $signed({start_q[23], start_q});
  assign ang_prod = $signed({1'b0, t0_q}) * ang_span;
  assign orb_turn = {start_q[15:0], 16'h0000} + ang_prod[31:0];
  assign wav_turn = {t0_q[15:0], 16'h0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_v_q <= 1'b0;
    end else if (adv) begin
      ph_v_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_orb_q <= orb_turn[31 -: PHASE_BITS];
      ph_wav_q <= wav_turn[31 -: PHASE_BITS];
      ph_t_q   <= t0_q;
    end
  end

  // --------------------------------------------------------------------------
  // Two CORDIC rotators side by side, one rotation per stage
  // --------------------------------------------------------------------------
  logic [31:0] orb_a, wav_a;
  cordic_t     orb_init, wav_init;

  assign orb_a    = {ph_orb_q, {PAD{1'b0}}};
  assign wav_a    = {ph_wav_q, {PAD{1'b0}}};
  assign orb_init = cordic_init(orb_a);
  assign wav_init = cordic_init(wav_a);

  cordic_t     co_q [NST];
  cordic_t     cw_q [NST];
  logic [NST-1:0] cv_q, cof_q, cwf_q;
  logic [16:0] ct_q [NST];

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    cordic_t     o_in, w_in;
    logic        v_in, of_in, wf_in;
    logic [16:0] t_in;

    if (i == 0) begin : g_first
      assign o_in  = orb_init;
      assign w_in  = wav_init;
      assign v_in  = ph_v_q;
      assign of_in = orb_a[31] ^ orb_a[30];  // angle in the back half turn
      assign wf_in = wav_a[31] ^ wav_a[30];
      assign t_in  = ph_t_q;
    end else begin : g_next
      assign o_in  = co_q[i-1];
      assign w_in  = cw_q[i-1];
      assign v_in  = cv_q[i-1];
      assign of_in = cof_q[i-1];
      assign wf_in = cwf_q[i-1];
      assign t_in  = ct_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (adv) begin
        cv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        co_q[i]  <= cordic_rot(o_in, i);
        cw_q[i]  <= cordic_rot(w_in, i);
        cof_q[i] <= of_in;
        cwf_q[i] <= wf_in;
        ct_q[i]  <= t_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // M1: undo the fold
  // --------------------------------------------------------------------------
  logic               m1_v_q;
  logic signed [31:0] oc_q, os_q, ws_q;
  logic [16:0]        m1_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= cv_q[CLST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc_q   <= cof_q[CLST] ? -co_q[CLST].x : co_q[CLST].x;
      os_q   <= cof_q[CLST] ? -co_q[CLST].y : co_q[CLST].y;
      ws_q   <= cwf_q[CLST] ? -cw_q[CLST].y : cw_q[CLST].y;
      m1_t_q <= ct_q[CLST];
    end
  end

  // --------------------------------------------------------------------------
  // M2: length times sine products
  // --------------------------------------------------------------------------
  logic               m2_v_q;
  logic signed [63:0] m2_rc_q, m2_rs_q, m2_hw_q, m2_rw_q;
  logic signed [50:0] m2_hel_q;
  logic signed [18:0] hel_k;

  // 2t - 1.0 for the helix rise
  assign hel_k = $signed({1'b0, m1_t_q, 1'b0}) - 19'sd65536;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_rc_q  <= rad_s * oc_q;
      m2_rs_q  <= rad_s * os_q;
      m2_hw_q  <= height_q * ws_q;
      m2_rw_q  <= rad_s * ws_q;
      m2_hel_q <= hel_k * height_q;
    end
  end

  // --------------------------------------------------------------------------
  // M3: round to Q16.16, add center for the flat modes, wave value v
  // --------------------------------------------------------------------------
  logic signed [63:0] rnd_x, rnd_y, rnd_hw, rnd_v;
  logic signed [50:0] rnd_hel;
  logic signed [35:0] cx36, cy36, cz36, fz_sum;
  logic signed [32:0] v_w;
  logic               m3_v_q;
  point_t             m3_flat_q;
  logic signed [32:0] m3_vv_q;
  logic [31:0]        m3_av_q;
  logic signed [63:0] m3_rc_q, m3_rs_q;

  assign cx36    = $signed({{4{center_x_q[31]}}, center_x_q});
  assign cy36    = $signed({{4{center_y_q[31]}}, center_y_q});
  assign cz36    = $signed({{4{center_z_q[31]}}, center_z_q});
  assign rnd_x   = (m2_rc_q + 64'sd536870912) >>> 30;
  assign rnd_y   = (m2_rs_q + 64'sd536870912) >>> 30;
  assign rnd_hw  = (m2_hw_q + 64'sd536870912) >>> 30;
  assign rnd_v   = (m2_rw_q + 64'sd536870912) >>> 30;
  assign rnd_hel = (m2_hel_q + 51'sd32768) >>> 16;
  assign v_w     = rnd_v[32:0];

  always_comb begin
    unique case (mode_q)
      MODE_CYL:   fz_sum = cz36 + rnd_hw[35:0];
      MODE_HELIX: fz_sum = cz36 + rnd_hel[35:0];
      MODE_FLAT, MODE_SPHERE: fz_sum = cz36;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (adv) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_flat_q.x <= sat32(cx36 + rnd_x[35:0]);
      m3_flat_q.y <= sat32(cy36 + rnd_y[35:0]);
      m3_flat_q.z <= sat32(fz_sum);
      m3_vv_q     <= v_w;
      m3_av_q     <= v_w[32] ? 32'(-v_w) : v_w[31:0];
      m3_rc_q     <= m2_rc_q;
      m3_rs_q     <= m2_rs_q;
    end
  end

  // --------------------------------------------------------------------------
  // M4: 1 + v^2 in Q32.32, r*v numerator
  // --------------------------------------------------------------------------
  logic signed [64:0] rv_full;
  logic               m4_v_q;
  logic [63:0]        m4_sq_q;
  logic signed [63:0] m4_rv_q, m4_rc_q, m4_rs_q;
  point_t             m4_flat_q;

  assign rv_full = rad_s * m3_vv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_v_q <= 1'b0;
    end else if (adv) begin
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4_sq_q   <= {32'd0, m3_av_q} * {32'd0, m3_av_q} + 64'h0000_0001_0000_0000;
      m4_rv_q   <= rv_full[63:0];
      m4_rc_q   <= m3_rc_q;
      m4_rs_q   <= m3_rs_q;
      m4_flat_q <= m3_flat_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one result bit per stage
  // --------------------------------------------------------------------------
  sqrt_t              sq_q   [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] sqv_q;
  logic signed [63:0] sq_rc_q [SQRT_STAGES];
  logic signed [63:0] sq_rs_q [SQRT_STAGES];
  logic signed [63:0] sq_rv_q [SQRT_STAGES];
  point_t             sq_fl_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    sqrt_t              s_in;
    logic               v_in;
    logic signed [63:0] rc_in, rs_in, rv_in;
    point_t             fl_in;

    if (k == 0) begin : g_first
      assign s_in.n = m4_sq_q;
      assign s_in.r = '0;
      assign v_in   = m4_v_q;
      assign rc_in  = m4_rc_q;
      assign rs_in  = m4_rs_q;
      assign rv_in  = m4_rv_q;
      assign fl_in  = m4_flat_q;
    end else begin : g_next
      assign s_in  = sq_q[k-1];
      assign v_in  = sqv_q[k-1];
      assign rc_in = sq_rc_q[k-1];
      assign rs_in = sq_rs_q[k-1];
      assign rv_in = sq_rv_q[k-1];
      assign fl_in = sq_fl_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k] <= 1'b0;
      end else if (adv) begin
        sqv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k]    <= sqrt_step(s_in, k);
        sq_rc_q[k] <= rc_in;
        sq_rs_q[k] <= rs_in;
        sq_rv_q[k] <= rv_in;
        sq_fl_q[k] <= fl_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider setup: magnitudes plus half divisor for round-half-away
  // --------------------------------------------------------------------------
  logic [31:0] root_w;
  logic [63:0] mag_x, mag_y, mag_z;
  logic        dp_v_q;
  logic [63:0] dp_num_x_q, dp_num_y_q, dp_num_z_q;
  logic [2:0]  dp_neg_q;
  logic [45:0] dp_den_xy_q;
  logic [31:0] dp_den_z_q;
  point_t      dp_flat_q;

  assign root_w = sq_q[SLST].r[31:0];
  assign mag_x  = sq_rc_q[SLST][63] ? 64'(-sq_rc_q[SLST]) : sq_rc_q[SLST];
  assign mag_y  = sq_rs_q[SLST][63] ? 64'(-sq_rs_q[SLST]) : sq_rs_q[SLST];
  assign mag_z  = sq_rv_q[SLST][63] ? 64'(-sq_rv_q[SLST]) : sq_rv_q[SLST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_v_q <= 1'b0;
    end else if (adv) begin
      dp_v_q <= sqv_q[SLST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_num_x_q  <= mag_x + {19'd0, root_w, 13'd0};
      dp_num_y_q  <= mag_y + {19'd0, root_w, 13'd0};
      dp_num_z_q  <= mag_z + {33'd0, root_w[31:1]};
      dp_neg_q    <= {sq_rv_q[SLST][63], sq_rs_q[SLST][63], sq_rc_q[SLST][63]};
      dp_den_xy_q <= {root_w, 14'd0};
      dp_den_z_q  <= root_w;
      dp_flat_q   <= sq_fl_q[SLST];
    end
  end

  // --------------------------------------------------------------------------
  // Three restoring dividers, one quotient bit per stage, MSB first
  // --------------------------------------------------------------------------
  div_t        dx_q [QUOT_BITS];
  div_t        dy_q [QUOT_BITS];
  div_t        dz_q [QUOT_BITS];
  logic [QUOT_BITS-1:0] dv_q;
  logic [2:0]  dneg_q [QUOT_BITS];
  logic [45:0] dden_xy_q [QUOT_BITS];
  logic [31:0] dden_z_q [QUOT_BITS];
  point_t      dfl_q [QUOT_BITS];

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    div_t        x_in, y_in, z_in;
    logic        v_in;
    logic [2:0]  neg_in;
    logic [45:0] dxy_in;
    logic [31:0] dz_in;
    point_t      fl_in;

    if (j == 0) begin : g_first
      assign x_in.rem = dp_num_x_q;
      assign x_in.quo = '0;
      assign y_in.rem = dp_num_y_q;
      assign y_in.quo = '0;
      assign z_in.rem = dp_num_z_q;
      assign z_in.quo = '0;
      assign v_in     = dp_v_q;
      assign neg_in   = dp_neg_q;
      assign dxy_in   = dp_den_xy_q;
      assign dz_in    = dp_den_z_q;
      assign fl_in    = dp_flat_q;
    end else begin : g_next
      assign x_in   = dx_q[j-1];
      assign y_in   = dy_q[j-1];
      assign z_in   = dz_q[j-1];
      assign v_in   = dv_q[j-1];
      assign neg_in = dneg_q[j-1];
      assign dxy_in = dden_xy_q[j-1];
      assign dz_in  = dden_z_q[j-1];
      assign fl_in  = dfl_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (adv) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dx_q[j]      <= div_step(x_in, dxy_in, DLST - j);
        dy_q[j]      <= div_step(y_in, dxy_in, DLST - j);
        dz_q[j]      <= div_step(z_in, {14'd0, dz_in}, DLST - j);
        dneg_q[j]    <= neg_in;
        dden_xy_q[j] <= dxy_in;
        dden_z_q[j]  <= dz_in;
        dfl_q[j]     <= fl_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: signed quotients plus center, mode select
  // --------------------------------------------------------------------------
  logic signed [35:0] qx36, qy36, qz36;
  point_t             sph;
  point_t             pick;
  logic [31:0]        point_x_q, point_y_q, point_z_q;

  assign qx36  = dneg_q[DLST][0] ? -$signed({3'b000, dx_q[DLST].quo})
                                 :  $signed({3'b000, dx_q[DLST].quo});
  assign qy36  = dneg_q[DLST][1] ? -$signed({3'b000, dy_q[DLST].quo})
                                 :  $signed({3'b000, dy_q[DLST].quo});
  assign qz36  = dneg_q[DLST][2] ? -$signed({3'b000, dz_q[DLST].quo})
                                 :  $signed({3'b000, dz_q[DLST].quo});
  assign sph.x = sat32(cx36 + qx36);
  assign sph.y = sat32(cy36 + qy36);
  assign sph.z = sat32(cz36 + qz36);
  assign pick  = (mode_q == MODE_SPHERE) ? sph : dfl_q[DLST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[DLST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      point_x_q <= pick.x;
      point_y_q <= pick.y;
      point_z_q <= pick.z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = $signed(point_x_q);
  assign point_y_o   = $signed(point_y_q);
  assign point_z_o   = $signed(point_z_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `OPP_ASSERT(a_ready_when_out_free, clk_i, rst_ni, !out_valid_q |-> in_ready_o)
  `OPP_ASSERT(a_take_fills_entry, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> v0_q)
  `OPP_ASSERT_NEVER(a_root_below_one, clk_i, rst_ni, dp_v_q && (dp_den_z_q[31:16] == 16'd0))
  `OPP_ASSERT(a_stall_holds_entry, clk_i, rst_ni, (v0_q && !adv) |=> v0_q)

endmodule
